@@ rtl/sra_pkg.sv @@
`timescale 1ns / 1ps

package sra_pkg;

    localparam int SEQ_W       = 7;
    localparam int NB_W        = 2;
    localparam int HANDLE_W    = 16;
    localparam int FB_W        = 3;
    localparam int SLOT_W      = 2;
    localparam int SLOT_IDX_W  = NB_W + SLOT_W;
    localparam int SLOT_TOTAL  = 1 << SLOT_IDX_W;
    localparam int LINK_COUNT  = 1 << NB_W;
    localparam int WINDOW_SLOTS = 1 << SLOT_W;

    localparam logic [1:0] OP_SEND      = 2'd0;
    localparam logic [1:0] OP_ARRIVAL   = 2'd1;
    localparam logic [1:0] OP_FRAME_TMO = 2'd2;
    localparam logic [1:0] OP_ACK_TMO   = 2'd3;

    localparam logic [1:0] FT_DATA = 2'd0;
    localparam logic [1:0] FT_ACK  = 2'd1;
    localparam logic [1:0] FT_NAK  = 2'd2;

    typedef enum logic [2:0] {
        ACT_TRANSMIT = 3'd0,
        ACT_DELIVER  = 3'd1,
        ACT_START_FT = 3'd2,
        ACT_STOP_FT  = 3'd3,
        ACT_START_AT = 3'd4,
        ACT_STOP_AT  = 3'd5,
        ACT_WIN_FULL = 3'd6
    } t_act;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD,
        ST_TXDATA,
        ST_STARTFT,
        ST_STOPAT,
        ST_NAK,
        ST_ACKSTART,
        ST_STORE,
        ST_DLVCHK,
        ST_DLV,
        ST_DLVACK,
        ST_CUM,
        ST_FLUSH
    } t_state;

    typedef enum logic [4:0] {
        C_NONE,
        C_LATCH,
        C_SEND_SETUP,
        C_NAKRS_SETUP,
        C_TMR_SETUP,
        C_EMIT_TXDATA,
        C_EMIT_STARTFT,
        C_EMIT_STOPAT,
        C_EMIT_TXNAK,
        C_EMIT_TXACK,
        C_EMIT_STARTAT,
        C_EMIT_WFULL,
        C_STORE,
        C_EMIT_DLV,
        C_EMIT_STOPFT,
        C_FLUSH
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
        logic       emit_ok;
        logic       can_push;
        logic       pend_valid;
        logic       win_full;
        logic       seq_ne_exp;
        logic       nak_ok;
        logic       atr;
        logic       rx_store_ok;
        logic       arrived_exp;
        logic       nak_resend_ok;
        logic       cum_ok;
        logic       tmr_ok;
    } t_sts;

    // True when b lies in the circular window [a, c).
    function automatic logic in_win(input logic [SEQ_W-1:0] a,
                                    input logic [SEQ_W-1:0] b,
                                    input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

@@ rtl/sra_ram.sv @@
`timescale 1ns / 1ps

module sra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sra_dpath.sv @@
`timescale 1ns / 1ps

module sra_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sra_pkg::t_cmd                i_cmd,
    output sra_pkg::t_sts                o_sts,
    input  logic [1:0]                   i_opcode,
    input  logic [sra_pkg::NB_W-1:0]     i_neighbour_index,
    input  logic [1:0]                   i_frame_type,
    input  logic [sra_pkg::SEQ_W-1:0]    i_seq_number,
    input  logic [sra_pkg::SEQ_W-1:0]    i_ack_number,
    input  logic [sra_pkg::HANDLE_W-1:0] i_payload_handle,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [2:0]                   o_action,
    output logic [sra_pkg::NB_W-1:0]     o_out_neighbour,
    output logic [1:0]                   o_out_frame_type,
    output logic [sra_pkg::SEQ_W-1:0]    o_out_seq,
    output logic [sra_pkg::SEQ_W-1:0]    o_out_ack,
    output logic [sra_pkg::HANDLE_W-1:0] o_out_handle,
    output logic                         o_last
);

    // Item latch.
    logic [1:0]                   r_op;
    logic [sra_pkg::NB_W-1:0]     r_nb;
    logic [1:0]                   r_kind;
    logic [sra_pkg::SEQ_W-1:0]    r_seq;
    logic [sra_pkg::SEQ_W-1:0]    r_ack;
    logic [sra_pkg::HANDLE_W-1:0] r_handle;
    logic [sra_pkg::SEQ_W-1:0]    r_txseq;

    // Per-link window state.
    logic [sra_pkg::SEQ_W-1:0] r_low  [sra_pkg::LINK_COUNT];
    logic [sra_pkg::SEQ_W-1:0] r_next [sra_pkg::LINK_COUNT];
    logic [sra_pkg::SEQ_W-1:0] r_exp  [sra_pkg::LINK_COUNT];
    logic [sra_pkg::SEQ_W-1:0] r_up   [sra_pkg::LINK_COUNT];
    logic [sra_pkg::FB_W-1:0]  r_fb   [sra_pkg::LINK_COUNT];
    logic [sra_pkg::LINK_COUNT-1:0] r_nak;
    logic [sra_pkg::LINK_COUNT-1:0] r_atr;
    logic [sra_pkg::SLOT_TOTAL-1:0] r_arr;

    // One action is held back so that the final one can carry the last flag.
    logic                         r_pv;
    logic [2:0]                   r_p_act;
    logic [1:0]                   r_p_ft;
    logic [sra_pkg::SEQ_W-1:0]    r_p_seq;
    logic [sra_pkg::SEQ_W-1:0]    r_p_ack;
    logic [sra_pkg::HANDLE_W-1:0] r_p_handle;

    logic                         r_ov;
    logic [2:0]                   r_o_act;
    logic [sra_pkg::NB_W-1:0]     r_o_nb;
    logic [1:0]                   r_o_ft;
    logic [sra_pkg::SEQ_W-1:0]    r_o_seq;
    logic [sra_pkg::SEQ_W-1:0]    r_o_ack;
    logic [sra_pkg::HANDLE_W-1:0] r_o_handle;
    logic                         r_o_last;

    logic [sra_pkg::SEQ_W-1:0]      w_low, w_next, w_exp, w_up, w_ack1, w_ackf;
    logic [sra_pkg::FB_W-1:0]       w_fb;
    logic [sra_pkg::SLOT_IDX_W-1:0] w_slot_tx, w_slot_exp, w_slot_seq, w_slot_next;
    logic [sra_pkg::HANDLE_W-1:0]   w_send_rdata, w_recv_rdata;
    logic                           w_emit, w_push, w_can_push;
    logic [2:0]                     n_act;
    logic [1:0]                     n_ft;
    logic [sra_pkg::SEQ_W-1:0]      n_seq, n_ack;
    logic [sra_pkg::HANDLE_W-1:0]   n_handle;

    assign w_low  = r_low[r_nb];
    assign w_next = r_next[r_nb];
    assign w_exp  = r_exp[r_nb];
    assign w_up   = r_up[r_nb];
    assign w_fb   = r_fb[r_nb];
    assign w_ack1 = r_ack + sra_pkg::SEQ_W'(1);
    assign w_ackf = w_exp - sra_pkg::SEQ_W'(1);

    assign w_slot_tx   = {r_nb, r_txseq[sra_pkg::SLOT_W-1:0]};
    assign w_slot_exp  = {r_nb, w_exp[sra_pkg::SLOT_W-1:0]};
    assign w_slot_seq  = {r_nb, r_seq[sra_pkg::SLOT_W-1:0]};
    assign w_slot_next = {r_nb, w_next[sra_pkg::SLOT_W-1:0]};

    sra_ram #(.WIDTH(sra_pkg::HANDLE_W), .DEPTH(sra_pkg::SLOT_TOTAL)) u_send_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd == sra_pkg::C_SEND_SETUP),
        .i_waddr (w_slot_next),
        .i_wdata (r_handle),
        .i_raddr (w_slot_tx),
        .o_rdata (w_send_rdata)
    );

    sra_ram #(.WIDTH(sra_pkg::HANDLE_W), .DEPTH(sra_pkg::SLOT_TOTAL)) u_recv_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd == sra_pkg::C_STORE),
        .i_waddr (w_slot_seq),
        .i_wdata (r_handle),
        .i_raddr (w_slot_exp),
        .o_rdata (w_recv_rdata)
    );

    always_comb begin
        w_emit = i_cmd inside {sra_pkg::C_EMIT_TXDATA, sra_pkg::C_EMIT_STARTFT,
                               sra_pkg::C_EMIT_STOPAT, sra_pkg::C_EMIT_TXNAK,
                               sra_pkg::C_EMIT_TXACK, sra_pkg::C_EMIT_STARTAT,
                               sra_pkg::C_EMIT_WFULL, sra_pkg::C_EMIT_DLV,
                               sra_pkg::C_EMIT_STOPFT};
        n_act    = sra_pkg::ACT_TRANSMIT;
        n_ft     = sra_pkg::FT_DATA;
        n_seq    = '0;
        n_ack    = '0;
        n_handle = '0;
        case (i_cmd)
            sra_pkg::C_EMIT_TXDATA: begin
                n_seq    = r_txseq;
                n_ack    = w_ackf;
                n_handle = w_send_rdata;
            end
            sra_pkg::C_EMIT_STARTFT: begin
                n_act = sra_pkg::ACT_START_FT;
                n_seq = r_txseq;
            end
            sra_pkg::C_EMIT_STOPAT:  n_act = sra_pkg::ACT_STOP_AT;
            sra_pkg::C_EMIT_TXNAK: begin
                n_ft  = sra_pkg::FT_NAK;
                n_ack = w_ackf;
            end
            sra_pkg::C_EMIT_TXACK: begin
                n_ft  = sra_pkg::FT_ACK;
                n_ack = w_ackf;
            end
            sra_pkg::C_EMIT_STARTAT: n_act = sra_pkg::ACT_START_AT;
            sra_pkg::C_EMIT_WFULL: begin
                n_act    = sra_pkg::ACT_WIN_FULL;
                n_handle = r_handle;
            end
            sra_pkg::C_EMIT_DLV: begin
                n_act    = sra_pkg::ACT_DELIVER;
                n_handle = w_recv_rdata;
            end
            sra_pkg::C_EMIT_STOPFT: begin
                n_act = sra_pkg::ACT_STOP_FT;
                n_seq = w_low;
            end
            default: ;
        endcase
    end

    assign w_can_push = !r_ov || !i_out_stall;
    assign w_push     = (w_emit && r_pv) || (i_cmd == sra_pkg::C_FLUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sra_pkg::LINK_COUNT; i++) begin
                r_low[i]  <= '0;
                r_next[i] <= '0;
                r_exp[i]  <= '0;
                r_up[i]   <= sra_pkg::SEQ_W'(sra_pkg::WINDOW_SLOTS);
                r_fb[i]   <= '0;
            end
            r_nak <= '0;
            r_atr <= '0;
            r_arr <= '0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (w_emit) begin
                r_pv <= 1'b1;
            end else if (i_cmd == sra_pkg::C_FLUSH) begin
                r_pv <= 1'b0;
            end
            case (i_cmd)
                sra_pkg::C_SEND_SETUP: begin
                    r_fb[r_nb]   <= w_fb + sra_pkg::FB_W'(1);
                    r_next[r_nb] <= w_next + sra_pkg::SEQ_W'(1);
                end
                sra_pkg::C_EMIT_STOPAT, sra_pkg::C_EMIT_TXACK: r_atr[r_nb] <= 1'b0;
                sra_pkg::C_EMIT_TXNAK:   r_nak[r_nb] <= 1'b0;
                sra_pkg::C_EMIT_STARTAT: r_atr[r_nb] <= 1'b1;
                sra_pkg::C_STORE:        r_arr[w_slot_seq] <= 1'b1;
                sra_pkg::C_EMIT_DLV: begin
                    r_arr[w_slot_exp] <= 1'b0;
                    r_nak[r_nb]       <= 1'b1;
                    r_exp[r_nb]       <= w_exp + sra_pkg::SEQ_W'(1);
                    r_up[r_nb]        <= w_up + sra_pkg::SEQ_W'(1);
                end
                sra_pkg::C_EMIT_STOPFT: begin
                    if (w_fb != '0) begin
                        r_fb[r_nb] <= w_fb - sra_pkg::FB_W'(1);
                    end
                    r_low[r_nb] <= w_low + sra_pkg::SEQ_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == sra_pkg::C_LATCH) begin
            r_op     <= i_opcode;
            r_nb     <= i_neighbour_index;
            r_kind   <= i_frame_type;
            r_seq    <= i_seq_number;
            r_ack    <= i_ack_number;
            r_handle <= i_payload_handle;
        end
        case (i_cmd)
            sra_pkg::C_SEND_SETUP:  r_txseq <= w_next;
            sra_pkg::C_NAKRS_SETUP: r_txseq <= w_ack1;
            sra_pkg::C_TMR_SETUP:   r_txseq <= r_seq;
            default: ;
        endcase
        if (w_push) begin
            r_o_act    <= r_p_act;
            r_o_nb     <= r_nb;
            r_o_ft     <= r_p_ft;
            r_o_seq    <= r_p_seq;
            r_o_ack    <= r_p_ack;
            r_o_handle <= r_p_handle;
            r_o_last   <= (i_cmd == sra_pkg::C_FLUSH);
        end
        if (w_emit) begin
            r_p_act    <= n_act;
            r_p_ft     <= n_ft;
            r_p_seq    <= n_seq;
            r_p_ack    <= n_ack;
            r_p_handle <= n_handle;
        end
    end

    always_comb begin
        o_sts.op            = r_op;
        o_sts.kind          = r_kind;
        o_sts.can_push      = w_can_push;
        o_sts.emit_ok       = !r_pv || w_can_push;
        o_sts.pend_valid    = r_pv;
        o_sts.win_full      = w_fb >= sra_pkg::FB_W'(sra_pkg::WINDOW_SLOTS);
        o_sts.seq_ne_exp    = r_seq != w_exp;
        o_sts.nak_ok        = r_nak[r_nb];
        o_sts.atr           = r_atr[r_nb];
        o_sts.rx_store_ok   = sra_pkg::in_win(w_exp, r_seq, w_up) && !r_arr[w_slot_seq];
        o_sts.arrived_exp   = r_arr[w_slot_exp];
        o_sts.nak_resend_ok = sra_pkg::in_win(w_low, w_ack1, w_next);
        o_sts.cum_ok        = sra_pkg::in_win(w_low, r_ack, w_next);
        o_sts.tmr_ok        = sra_pkg::in_win(w_low, r_seq, w_next);
    end

    assign o_out_valid      = r_ov;
    assign o_action         = r_o_act;
    assign o_out_neighbour  = r_o_nb;
    assign o_out_frame_type = r_o_ft;
    assign o_out_seq        = r_o_seq;
    assign o_out_ack        = r_o_ack;
    assign o_out_handle     = r_o_handle;
    assign o_last           = r_o_last;

endmodule

@@ rtl/sra_ctrl.sv @@
`timescale 1ns / 1ps

module sra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  sra_pkg::t_sts  i_sts,
    output sra_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    sra_pkg::t_state r_state, n_state;
    sra_pkg::t_state w_after_send;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Where a transmitted frame's sequence returns to, by event kind.
    always_comb begin
        if (i_sts.op == sra_pkg::OP_ARRIVAL && i_sts.kind == sra_pkg::FT_DATA) begin
            w_after_send = sra_pkg::ST_STORE;
        end else if (i_sts.op == sra_pkg::OP_ARRIVAL) begin
            w_after_send = sra_pkg::ST_CUM;
        end else begin
            w_after_send = sra_pkg::ST_FLUSH;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = sra_pkg::C_NONE;
        case (r_state)
            sra_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = sra_pkg::C_LATCH;
                    n_state = sra_pkg::ST_DISPATCH;
                end
            end
            sra_pkg::ST_DISPATCH: begin
                // Nothing is pending here, so an action can always be taken.
                case (i_sts.op)
                    sra_pkg::OP_SEND: begin
                        if (i_sts.win_full) begin
                            o_cmd   = sra_pkg::C_EMIT_WFULL;
                            n_state = sra_pkg::ST_FLUSH;
                        end else begin
                            o_cmd   = sra_pkg::C_SEND_SETUP;
                            n_state = sra_pkg::ST_RD;
                        end
                    end
                    sra_pkg::OP_ARRIVAL: begin
                        if (i_sts.kind == sra_pkg::FT_DATA) begin
                            n_state = (i_sts.seq_ne_exp && i_sts.nak_ok) ?
                                      sra_pkg::ST_NAK : sra_pkg::ST_ACKSTART;
                        end else if (i_sts.kind == sra_pkg::FT_NAK && i_sts.nak_resend_ok) begin
                            o_cmd   = sra_pkg::C_NAKRS_SETUP;
                            n_state = sra_pkg::ST_RD;
                        end else begin
                            n_state = sra_pkg::ST_CUM;
                        end
                    end
                    sra_pkg::OP_FRAME_TMO: begin
                        if (i_sts.tmr_ok) begin
                            o_cmd   = sra_pkg::C_TMR_SETUP;
                            n_state = sra_pkg::ST_RD;
                        end else begin
                            n_state = sra_pkg::ST_FLUSH;
                        end
                    end
                    default: begin
                        if (i_sts.atr) begin
                            o_cmd = sra_pkg::C_EMIT_TXACK;
                        end
                        n_state = sra_pkg::ST_FLUSH;
                    end
                endcase
            end
            sra_pkg::ST_RD: n_state = sra_pkg::ST_TXDATA;
            sra_pkg::ST_TXDATA: begin
                if (i_sts.emit_ok) begin
                    o_cmd   = sra_pkg::C_EMIT_TXDATA;
                    n_state = sra_pkg::ST_STARTFT;
                end
            end
            sra_pkg::ST_STARTFT: begin
                if (i_sts.emit_ok) begin
                    o_cmd   = sra_pkg::C_EMIT_STARTFT;
                    n_state = sra_pkg::ST_STOPAT;
                end
            end
            sra_pkg::ST_NAK: begin
                if (i_sts.emit_ok) begin
                    o_cmd   = sra_pkg::C_EMIT_TXNAK;
                    n_state = sra_pkg::ST_STOPAT;
                end
            end
            sra_pkg::ST_STOPAT: begin
                if (!i_sts.atr) begin
                    n_state = w_after_send;
                end else if (i_sts.emit_ok) begin
                    o_cmd   = sra_pkg::C_EMIT_STOPAT;
                    n_state = w_after_send;
                end
            end
            sra_pkg::ST_ACKSTART: begin
                if (i_sts.atr) begin
                    n_state = sra_pkg::ST_STORE;
                end else if (i_sts.emit_ok) begin
                    o_cmd   = sra_pkg::C_EMIT_STARTAT;
                    n_state = sra_pkg::ST_STORE;
                end
            end
            sra_pkg::ST_STORE: begin
                if (i_sts.rx_store_ok) begin
                    o_cmd   = sra_pkg::C_STORE;
                    n_state = sra_pkg::ST_DLVCHK;
                end else begin
                    n_state = sra_pkg::ST_CUM;
                end
            end
            sra_pkg::ST_DLVCHK: begin
                n_state = i_sts.arrived_exp ? sra_pkg::ST_DLV : sra_pkg::ST_CUM;
            end
            sra_pkg::ST_DLV: begin
                if (i_sts.emit_ok) begin
                    o_cmd   = sra_pkg::C_EMIT_DLV;
                    n_state = sra_pkg::ST_DLVACK;
                end
            end
            sra_pkg::ST_DLVACK: begin
                if (i_sts.atr) begin
                    n_state = sra_pkg::ST_DLVCHK;
                end else if (i_sts.emit_ok) begin
                    o_cmd   = sra_pkg::C_EMIT_STARTAT;
                    n_state = sra_pkg::ST_DLVCHK;
                end
            end
            sra_pkg::ST_CUM: begin
                if (!i_sts.cum_ok) begin
                    n_state = sra_pkg::ST_FLUSH;
                end else if (i_sts.emit_ok) begin
                    o_cmd = sra_pkg::C_EMIT_STOPFT;
                end
            end
            sra_pkg::ST_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = sra_pkg::ST_IDLE;
                end else if (i_sts.can_push) begin
                    o_cmd   = sra_pkg::C_FLUSH;
                    n_state = sra_pkg::ST_IDLE;
                end
            end
            default: n_state = sra_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = r_state != sra_pkg::ST_IDLE;

endmodule

@@ rtl/selective_repeat_arq_engine.sv @@
// The shortest items are a window-full send, an ack-timer expiry and an ignored frame timer;
// the longest is a data arrival that delivers four slots and slides the send window by four.
// A send or a frame-timer resend runs through RD, TXDATA, STARTFT and STOPAT.
// One action is held back to carry the last flag; the final one is valid as o_stall drops.
// Items are taken one at a time; an output stall that holds an action lengthens the item.
// Reset (i_rst_n low, synchronous) clears window state, flags and arrival marks, not the RAMs.
`timescale 1ns / 1ps

module selective_repeat_arq_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_opcode,
    input  logic [sra_pkg::NB_W-1:0]     i_neighbour_index,
    input  logic [1:0]                   i_frame_type,
    input  logic [sra_pkg::SEQ_W-1:0]    i_seq_number,
    input  logic [sra_pkg::SEQ_W-1:0]    i_ack_number,
    input  logic [sra_pkg::HANDLE_W-1:0] i_payload_handle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_action,
    output logic [sra_pkg::NB_W-1:0]     o_out_neighbour,
    output logic [1:0]                   o_out_frame_type,
    output logic [sra_pkg::SEQ_W-1:0]    o_out_seq,
    output logic [sra_pkg::SEQ_W-1:0]    o_out_ack,
    output logic [sra_pkg::HANDLE_W-1:0] o_out_handle,
    output logic                         o_last
);

    sra_pkg::t_cmd w_cmd;
    sra_pkg::t_sts w_sts;

    sra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (o_stall)
    );

    sra_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_opcode          (i_opcode),
        .i_neighbour_index (i_neighbour_index),
        .i_frame_type      (i_frame_type),
        .i_seq_number      (i_seq_number),
        .i_ack_number      (i_ack_number),
        .i_payload_handle  (i_payload_handle),
        .i_out_stall       (i_stall),
        .o_out_valid       (o_valid),
        .o_action          (o_action),
        .o_out_neighbour   (o_out_neighbour),
        .o_out_frame_type  (o_out_frame_type),
        .o_out_seq         (o_out_seq),
        .o_out_ack         (o_out_ack),
        .o_out_handle      (o_out_handle),
        .o_last            (o_last)
    );

    // While idle, no held-back action may remain.
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !w_sts.pend_valid)
        else $error("action left pending while idle");

    // An action is only produced when the held-back one can move on.
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == sra_pkg::C_EMIT_TXDATA || w_cmd == sra_pkg::C_EMIT_STARTFT ||
         w_cmd == sra_pkg::C_EMIT_STOPAT || w_cmd == sra_pkg::C_EMIT_TXNAK ||
         w_cmd == sra_pkg::C_EMIT_TXACK || w_cmd == sra_pkg::C_EMIT_STARTAT ||
         w_cmd == sra_pkg::C_EMIT_WFULL || w_cmd == sra_pkg::C_EMIT_DLV ||
         w_cmd == sra_pkg::C_EMIT_STOPFT) |-> w_sts.emit_ok)
        else $error("action produced without room");

    // The engine leaves idle only on an accepted item.
    a_busy_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("engine busy without an item");

endmodule
